/* rtl/srt_pkg.sv */
// Shared types and constants for the smooth relation tester.
// No dependencies; every other file in rtl/ imports this package.
package srt_pkg;

    localparam int NUM_PRIMES     = 4;
    localparam int FBS_DEFAULT    = 4;
    localparam int PRIME_W        = 16;
    localparam int VALUE_W        = 31;
    localparam int WIDE_W         = 32;
    localparam int EXP_W          = 5;
    localparam int IDX_W          = 3;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int REG_IDX_W      = 3;

    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    // register map, word index = paddr[4:2]
    localparam logic [REG_IDX_W-1:0] REG_PRIME_0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRIME_1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRIME_2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRIME_3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_N = 3'd4;

    localparam logic [PRIME_W-1:0] PRIME_0_RST = 16'd2;
    localparam logic [PRIME_W-1:0] PRIME_1_RST = 16'd3;
    localparam logic [PRIME_W-1:0] PRIME_2_RST = 16'd5;
    localparam logic [PRIME_W-1:0] PRIME_3_RST = 16'd7;

    typedef logic [NUM_PRIMES-1:0][PRIME_W-1:0] prime_arr_t;
    typedef logic [NUM_PRIMES-1:0][EXP_W-1:0]   exp_arr_t;

    typedef struct packed {
        logic load_z;
        logic div_start;
        logic take_quot;
        logic next_prime;
        logic phase_end;
        logic load_s;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic idx_end;
        logic prime_small;
        logic value_trivial;
        logic value_one;
        logic phase;
        logic div_done;
        logic rem_zero;
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] echo_value;
        logic               candidate_smooth;
        logic               relation_found;
        exp_arr_t           z_exp;
        exp_arr_t           shifted_exp;
    } result_t;

endpackage

/* rtl/srt_divider.sv */
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Depends on srt_pkg.
module srt_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [srt_pkg::WIDE_W-1:0]   dividend,
    input  logic [srt_pkg::PRIME_W-1:0]  divisor,
    output logic [srt_pkg::WIDE_W-1:0]   quotient,
    output logic                         rem_zero,
    output logic                         done
);
    import srt_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic [WIDE_W-1:0]  q_reg, q_next;
    logic [PRIME_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [PRIME_W:0]   shift_val;
    logic [PRIME_W:0]   diff_val;
    logic               ge;

    assign shift_val = {r_reg, q_reg[WIDE_W-1]};
    assign diff_val  = shift_val - {1'b0, divisor};
    assign ge        = shift_val >= {1'b0, divisor};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[WIDE_W-2:0], ge};
            r_next   = ge ? diff_val[PRIME_W-1:0] : shift_val[PRIME_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quotient = q_reg;
    assign rem_zero = (r_reg == '0);
    assign done     = done_reg;

endmodule

/* rtl/srt_datapath.sv */
// Datapath: working value, prime index, exponent counters and smoothness
// flags, around the shared divider. Depends on srt_pkg and srt_divider.
module srt_datapath #(
    parameter int FACTOR_BASE_SIZE = srt_pkg::FBS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srt_pkg::cmd_t                 cmd,
    input  logic [srt_pkg::VALUE_W-1:0]   candidate_value,
    input  srt_pkg::prime_arr_t           primes,
    input  logic [srt_pkg::VALUE_W-1:0]   offset_n,
    output srt_pkg::status_t              status,
    output srt_pkg::result_t              result
);
    import srt_pkg::*;

    // sizes above the register count behave as the full register count
    localparam int USED = (FACTOR_BASE_SIZE > NUM_PRIMES) ? NUM_PRIMES : FACTOR_BASE_SIZE;

    logic [WIDE_W-1:0]  value_reg;
    logic [VALUE_W-1:0] echo_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               phase_reg;
    exp_arr_t           z_exp_reg;
    exp_arr_t           s_exp_reg;
    logic               z_smooth_reg;
    logic               rel_reg;

    logic [PRIME_W-1:0] cur_prime;
    logic [WIDE_W-1:0]  quotient;
    logic               rem_zero;
    logic               div_done;
    logic [1:0]         sel;

    assign sel       = idx_reg[1:0];
    assign cur_prime = primes[sel];

    srt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (value_reg),
        .divisor  (cur_prime),
        .quotient (quotient),
        .rem_zero (rem_zero),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            if (cmd.load_z || cmd.load_s) begin
                idx_reg <= '0;
            end else if (cmd.next_prime) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load_z) begin
                phase_reg <= 1'b0;
            end else if (cmd.load_s) begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_z) begin
            value_reg    <= {1'b0, candidate_value};
            echo_reg     <= candidate_value;
            z_exp_reg    <= '0;
            s_exp_reg    <= '0;
            z_smooth_reg <= 1'b0;
            rel_reg      <= 1'b0;
        end else begin
            if (cmd.load_s) begin
                // full-width sum, no wrap
                value_reg <= {1'b0, echo_reg} + {1'b0, offset_n};
            end else if (cmd.take_quot) begin
                value_reg <= quotient;
                if (!phase_reg) begin
                    if (z_exp_reg[sel] != EXP_MAX) begin
                        z_exp_reg[sel] <= z_exp_reg[sel] + 1'b1;
                    end
                end else if (s_exp_reg[sel] != EXP_MAX) begin
                    s_exp_reg[sel] <= s_exp_reg[sel] + 1'b1;
                end
            end
            if (cmd.phase_end) begin
                if (!phase_reg) begin
                    z_smooth_reg <= (value_reg == WIDE_W'(1));
                end else begin
                    rel_reg <= (value_reg == WIDE_W'(1));
                end
            end
        end
    end

    assign status.idx_end       = (idx_reg == IDX_W'(USED));
    assign status.prime_small   = (cur_prime[PRIME_W-1:1] == '0);
    assign status.value_trivial = (value_reg[WIDE_W-1:1] == '0);
    assign status.value_one     = (value_reg == WIDE_W'(1));
    assign status.phase         = phase_reg;
    assign status.div_done      = div_done;
    assign status.rem_zero      = rem_zero;

    assign result.echo_value       = echo_reg;
    assign result.candidate_smooth = z_smooth_reg;
    assign result.relation_found   = rel_reg;
    assign result.z_exp            = z_exp_reg;
    assign result.shifted_exp      = s_exp_reg;

endmodule

/* rtl/srt_ctrl.sv */
// Sequencer for the trial-division loop: walks primes, issues divides,
// switches to the shifted value and hands the result over. Depends on srt_pkg.
module srt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    input  srt_pkg::status_t  status,
    output srt_pkg::cmd_t     cmd
);
    import srt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_CHECK     = 5'b00010,
        S_DIV       = 5'b00100,
        S_PHASE_END = 5'b01000,
        S_DONE      = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_z = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // a cofactor of 0 or 1 can lose no further factor
                priority if (status.idx_end || status.value_trivial) begin
                    state_next = S_PHASE_END;
                end else if (status.prime_small) begin
                    cmd.next_prime = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        cmd.take_quot = 1'b1;
                    end else begin
                        cmd.next_prime = 1'b1;
                    end
                    state_next = S_CHECK;
                end
            end
            S_PHASE_END: begin
                cmd.phase_end = 1'b1;
                if (!status.phase && status.value_one) begin
                    cmd.load_s = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/smooth_relation_tester_core.sv */
// Top level of the smooth relation tester: register bank, output register,
// controller and datapath. Depends on srt_pkg, srt_ctrl and srt_datapath.
//
// Each candidate z is trial-divided by the configured primes through one
// bit-serial divider; each used prime of at least two takes its exponent
// plus one trial divisions, stopping early once the cofactor reaches zero
// or one, and primes below two are skipped without a divide. z + n is
// only worked on when z is smooth.
// One item is in work at a time; the next is taken while the previous
// result still sits in the output register. Primes and offset_n are
// written through the APB port; the user must write them only while the
// block is idle, as the block itself does not enforce this.
module smooth_relation_tester_core #(
    parameter int FACTOR_BASE_SIZE = srt_pkg::FBS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srt_pkg::PADDR_W-1:0]   paddr,
    input  logic [srt_pkg::PDATA_W-1:0]   pwdata,
    output logic [srt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [srt_pkg::VALUE_W-1:0]   s_candidate_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srt_pkg::VALUE_W-1:0]   m_echo_value,
    output logic                          m_candidate_smooth,
    output logic                          m_relation_found,
    output logic [srt_pkg::EXP_W-1:0]     m_z_exp_0,
    output logic [srt_pkg::EXP_W-1:0]     m_z_exp_1,
    output logic [srt_pkg::EXP_W-1:0]     m_z_exp_2,
    output logic [srt_pkg::EXP_W-1:0]     m_z_exp_3,
    output logic [srt_pkg::EXP_W-1:0]     m_shifted_exp_0,
    output logic [srt_pkg::EXP_W-1:0]     m_shifted_exp_1,
    output logic [srt_pkg::EXP_W-1:0]     m_shifted_exp_2,
    output logic [srt_pkg::EXP_W-1:0]     m_shifted_exp_3
);
    import srt_pkg::*;

    prime_arr_t          prime_reg;
    logic [VALUE_W-1:0]  offset_reg;
    logic                m_valid_reg;
    result_t             out_reg;
    result_t             result;
    cmd_t                cmd;
    status_t             status;
    logic                out_free;
    logic                cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg[0] <= PRIME_0_RST;
            prime_reg[1] <= PRIME_1_RST;
            prime_reg[2] <= PRIME_2_RST;
            prime_reg[3] <= PRIME_3_RST;
            offset_reg   <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PRIME_0:  prime_reg[0] <= pwdata[PRIME_W-1:0];
                REG_PRIME_1:  prime_reg[1] <= pwdata[PRIME_W-1:0];
                REG_PRIME_2:  prime_reg[2] <= pwdata[PRIME_W-1:0];
                REG_PRIME_3:  prime_reg[3] <= pwdata[PRIME_W-1:0];
                REG_OFFSET_N: offset_reg   <= pwdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PRIME_0:  prdata = PDATA_W'(prime_reg[0]);
            REG_PRIME_1:  prdata = PDATA_W'(prime_reg[1]);
            REG_PRIME_2:  prdata = PDATA_W'(prime_reg[2]);
            REG_PRIME_3:  prdata = PDATA_W'(prime_reg[3]);
            REG_OFFSET_N: prdata = PDATA_W'(offset_reg);
            default:      prdata = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    srt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    srt_datapath #(
        .FACTOR_BASE_SIZE (FACTOR_BASE_SIZE)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .candidate_value (s_candidate_value),
        .primes          (prime_reg),
        .offset_n        (offset_reg),
        .status          (status),
        .result          (result)
    );

    // output register: holds a finished result while the next item runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_echo_value       = out_reg.echo_value;
    assign m_candidate_smooth = out_reg.candidate_smooth;
    assign m_relation_found   = out_reg.relation_found;
    assign m_z_exp_0          = out_reg.z_exp[0];
    assign m_z_exp_1          = out_reg.z_exp[1];
    assign m_z_exp_2          = out_reg.z_exp[2];
    assign m_z_exp_3          = out_reg.z_exp[3];
    assign m_shifted_exp_0    = out_reg.shifted_exp[0];
    assign m_shifted_exp_1    = out_reg.shifted_exp[1];
    assign m_shifted_exp_2    = out_reg.shifted_exp[2];
    assign m_shifted_exp_3    = out_reg.shifted_exp[3];

    // a result never overwrites one that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending transfer");

    // an accepted item closes the input side in the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

    // shifted exponents only grow while the shifted value is worked on
    a_shift_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take_quot && !status.phase) |=> $stable(result.shifted_exp))
        else $error("shifted exponent changed during candidate phase");

endmodule
